[rtl/tomc_pkg.sv]
// Shared types, widths and codes for the threshold / opening / confidence block.
// No dependencies; every other file imports this package.
`default_nettype none

package tomc_pkg;

    // Frame geometry limits.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 4;

    // Fixed field widths.
    localparam int PROB_W     = 16;
    localparam int THR_W      = 17;
    localparam int KS_W       = 4;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Derived widths.
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int H_W     = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 2);
    localparam int R_W     = $clog2(MAX_RADIUS + 1);
    localparam int TAPS    = 2 * MAX_RADIUS;
    localparam int REACH_W = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int DLY_W   = $clog2(2 * (MAX_RADIUS * MAX_WIDTH + MAX_RADIUS) + 1);
    localparam int N_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int CMP_W   = ((N_W > DLY_W) ? N_W : DLY_W) + 1;
    localparam int SUM_W   = PROB_W + N_W;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    // Request type codes.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef enum logic {
        CMD_PIXEL,
        CMD_EMIT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                last;
        logic                bin;
        logic [PROB_W-1:0]   prob;
    } cmd_t;

    typedef struct packed {
        logic [W_W-1:0]     w;
        logic [H_W-1:0]     h;
        logic [R_W-1:0]     r;
        logic [REACH_W-1:0] reach;
        logic [N_W-1:0]     n;
    } frame_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_ERODE,
        B_DILATE,
        B_DIV,
        B_PUT
    } back_state_t;

endpackage

`default_nettype wire

[rtl/tomc_front.sv]
// Front end: configuration registers, frame latch, request classification.
// Depends on tomc_pkg; feeds tomc_queue.
`default_nettype none

module tomc_front
    import tomc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  req_type,
    input  wire logic [PROB_W-1:0]     probability,
    input  wire logic                  back_idle,
    input  wire queue_status_t         q_status,
    output logic                       push,
    output cmd_t                       push_cmd,
    output frame_t                     frame
);

    logic [THR_W-1:0] thr_reg;
    logic [KS_W-1:0]  ks_reg;
    logic [DIM_W-1:0] iw_reg;
    logic [DIM_W-1:0] ih_reg;

    logic             active_reg;
    logic [N_W-1:0]   rcv_reg;
    logic [N_W-1:0]   emt_reg;
    frame_t           frame_reg;
    logic [DLY_W-1:0] dly_reg;
    logic [THR_W-1:0] thr_cur_reg;

    logic [W_W-1:0]     w_c;
    logic [H_W-1:0]     h_c;
    logic [R_W-1:0]     r_c;
    logic [REACH_W-1:0] reach_c;
    frame_t             fresh;
    frame_t             cur;
    logic [DLY_W-1:0]   dly_c;
    logic [DLY_W-1:0]   cur_dly;
    logic [THR_W-1:0]   cur_thr;
    logic               acc;
    logic               drain_phase;
    logic               is_pixel;
    logic [N_W-1:0]     rcv_inc;
    logic [N_W-1:0]     emt_inc;
    logic               emit_px;
    logic               at_end;
    logic               last;

    assign cfg_ready = 1'b1;
    assign frame     = frame_reg;

    always_comb
    begin
        if (iw_reg == '0)
            w_c = W_W'(1);
        else if (int'(iw_reg) > MAX_WIDTH)
            w_c = W_W'(MAX_WIDTH);
        else
            w_c = W_W'(iw_reg);

        if (ih_reg == '0)
            h_c = H_W'(1);
        else if (int'(ih_reg) > MAX_HEIGHT)
            h_c = H_W'(MAX_HEIGHT);
        else
            h_c = H_W'(ih_reg);

        if (int'(ks_reg >> 1) > MAX_RADIUS)
            r_c = R_W'(MAX_RADIUS);
        else
            r_c = R_W'(ks_reg >> 1);

        reach_c     = REACH_W'(r_c * w_c) + REACH_W'(r_c);
        dly_c       = DLY_W'({reach_c, 1'b0});
        fresh.w     = w_c;
        fresh.h     = h_c;
        fresh.r     = r_c;
        fresh.reach = reach_c;
        fresh.n     = N_W'(w_c * h_c);

        cur     = active_reg ? frame_reg : fresh;
        cur_dly = active_reg ? dly_reg : dly_c;
        cur_thr = active_reg ? thr_cur_reg : thr_reg;
    end

    always_comb
    begin
        in_stall    = q_status.full || (!active_reg && !back_idle);
        acc         = in_valid && !in_stall;
        drain_phase = active_reg && (rcv_reg >= frame_reg.n);
        is_pixel    = !drain_phase && (req_type == REQ_PIXEL);
        rcv_inc     = rcv_reg + N_W'(1);
        emt_inc     = emt_reg + N_W'(1);
        emit_px     = (CMP_W'(emt_reg) + CMP_W'(cur_dly)) < CMP_W'(rcv_inc);
        at_end      = (emt_inc == cur.n);
        last        = drain_phase ? at_end : (emit_px && at_end);

        push          = acc && (drain_phase || is_pixel);
        push_cmd.kind = drain_phase ? CMD_EMIT : CMD_PIXEL;
        push_cmd.last = last;
        push_cmd.bin  = ({1'b0, probability} >= cur_thr);
        push_cmd.prob = probability;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(32768);
            ks_reg  <= '0;
            iw_reg  <= DIM_W'(1024);
            ih_reg  <= DIM_W'(1024);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:    thr_reg <= THR_W'(cfg_data);
                REG_KERNEL_SIZE:  ks_reg  <= KS_W'(cfg_data);
                REG_IMAGE_WIDTH:  iw_reg  <= DIM_W'(cfg_data);
                REG_IMAGE_HEIGHT: ih_reg  <= DIM_W'(cfg_data);
                default:          ;
            endcase
        end
    end

    // Frame counters and latched settings.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            rcv_reg     <= '0;
            emt_reg     <= '0;
            frame_reg   <= '0;
            dly_reg     <= '0;
            thr_cur_reg <= '0;
        end
        else if (acc)
        begin
            if (drain_phase)
            begin
                if (at_end)
                begin
                    active_reg <= 1'b0;
                    rcv_reg    <= '0;
                    emt_reg    <= '0;
                end
                else
                    emt_reg <= emt_inc;
            end
            else if (is_pixel)
            begin
                if (!active_reg)
                begin
                    frame_reg   <= fresh;
                    dly_reg     <= dly_c;
                    thr_cur_reg <= thr_reg;
                end
                if (last)
                begin
                    active_reg <= 1'b0;
                    rcv_reg    <= '0;
                    emt_reg    <= '0;
                end
                else
                begin
                    active_reg <= 1'b1;
                    rcv_reg    <= rcv_inc;
                    if (emit_px)
                        emt_reg <= emt_inc;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/tomc_queue.sv]
// Short command queue between front end and back end.
// Depends on tomc_pkg.
`default_nettype none

module tomc_queue
    import tomc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire cmd_t    push_cmd,
    input  wire logic    pop,
    output cmd_t         pop_cmd,
    output queue_status_t status
);

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;

    assign pop_cmd      = slot_reg[rd_ptr_reg];
    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == Q_CNT_W'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + Q_PTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + Q_CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - Q_CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

[rtl/tomc_window.sv]
// Square window min/max over a raster bit stream (erosion or dilation).
// Column memory of past rows plus a horizontal tap line; depends on tomc_pkg.
`default_nettype none

module tomc_window
    import tomc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   clear,
    input  wire logic   rd_en,
    input  wire logic   go,
    input  wire logic   use_or,
    input  wire logic   in_bit,
    input  wire frame_t frame,
    output logic        out_bit,
    output logic        out_valid
);

    logic [TAPS-1:0]    col_mem [MAX_WIDTH];
    logic [TAPS-1:0]    col_q_reg;
    logic [COL_W-1:0]   px_reg;
    logic [ROW_W-1:0]   py_reg;
    logic [COL_W-1:0]   cx_reg;
    logic [REACH_W-1:0] warm_reg;
    logic [TAPS-1:0]    hs_reg;

    logic [TAPS:0] vbits;
    logic [TAPS:0] vmask;
    logic [TAPS:0] hbits;
    logic [TAPS:0] hmask;
    logic          vres;
    logic          center_ok;

    // Read the column of past rows, then write it back shifted by one row.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            col_q_reg <= col_mem[px_reg];
        if (go)
            col_mem[px_reg] <= {col_q_reg[TAPS-2:0], in_bit};
    end

    always_comb
    begin
        vbits = {col_q_reg, in_bit};
        for (int i = 0; i <= TAPS; i++)
        begin
            vmask[i] = (i <= 2 * int'(frame.r)) && (int'(py_reg) >= i)
                       && (int'(py_reg) < int'(frame.h) + i);
        end
        vres = use_or ? |(vbits & vmask) : &(vbits | ~vmask);

        hbits = {hs_reg, vres};
        for (int j = 0; j <= TAPS; j++)
        begin
            hmask[j] = (j <= 2 * int'(frame.r))
                       && (int'(cx_reg) + int'(frame.r) >= j)
                       && (int'(cx_reg) + int'(frame.r) <= int'(frame.w) - 1 + j);
        end
        out_bit   = use_or ? |(hbits & hmask) : &(hbits | ~hmask);
        center_ok = (warm_reg == frame.reach);
        out_valid = go && center_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg   <= '0;
            py_reg   <= '0;
            cx_reg   <= '0;
            warm_reg <= '0;
            hs_reg   <= '0;
        end
        else if (clear)
        begin
            px_reg   <= '0;
            py_reg   <= '0;
            cx_reg   <= '0;
            warm_reg <= '0;
            hs_reg   <= '0;
        end
        else if (go)
        begin
            hs_reg <= {hs_reg[TAPS-2:0], vres};
            if (W_W'(px_reg) + W_W'(1) == frame.w)
            begin
                px_reg <= '0;
                py_reg <= py_reg + ROW_W'(1);
            end
            else
                px_reg <= px_reg + COL_W'(1);
            if (center_ok)
            begin
                if (W_W'(cx_reg) + W_W'(1) == frame.w)
                    cx_reg <= '0;
                else
                    cx_reg <= cx_reg + COL_W'(1);
            end
            else
                warm_reg <= warm_reg + REACH_W'(1);
        end
    end

endmodule

`default_nettype wire

[rtl/tomc_back.sv]
// Back end: runs erosion then dilation one raster step at a time, divides the
// frame sum for the confidence and holds the output register. Uses tomc_pkg, tomc_window.
`default_nettype none

module tomc_back
    import tomc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire frame_t        frame,
    input  wire queue_status_t q_status,
    output logic               pop,
    input  wire cmd_t          pop_cmd,
    output logic               back_idle,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               mask_bit,
    output logic               last_pixel,
    output logic [PROB_W-1:0]  confidence
);

    back_state_t            state_reg;
    back_state_t            state_next;
    cmd_t                   cmd_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [N_W-1:0]         rem_reg;
    logic [SUM_W-1:0]       dq_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic                   s1_bit_reg;
    logic                   s1_ok_reg;
    logic                   res_bit_reg;
    logic                   out_valid_reg;
    logic                   out_mask_reg;
    logic                   out_last_reg;
    logic [PROB_W-1:0]      out_conf_reg;

    logic rd_en;
    logic go1;
    logic go2;
    logic clear;
    logic div_init;
    logic div_step;
    logic load_out;
    logic out_free;
    logic s1_bit;
    logic s1_ok;
    logic s2_bit;
    logic s2_ok;
    logic in_bit;
    logic [N_W:0] rem_sh;
    logic         ge;

    assign out_valid  = out_valid_reg;
    assign mask_bit   = out_mask_reg;
    assign last_pixel = out_last_reg;
    assign confidence = out_conf_reg;
    assign back_idle  = (state_reg == B_IDLE) && q_status.empty;
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_bit     = (cmd_reg.kind == CMD_PIXEL) ? cmd_reg.bin : 1'b0;

    tomc_window u_erode (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .rd_en     (rd_en),
        .go        (go1),
        .use_or    (1'b0),
        .in_bit    (in_bit),
        .frame     (frame),
        .out_bit   (s1_bit),
        .out_valid (s1_ok)
    );

    tomc_window u_dilate (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .rd_en     (rd_en),
        .go        (go2),
        .use_or    (1'b1),
        .in_bit    (s1_bit_reg),
        .frame     (frame),
        .out_bit   (s2_bit),
        .out_valid (s2_ok)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (!q_status.empty)
                    state_next = B_READ;
            B_READ:
                state_next = B_ERODE;
            B_ERODE:
                state_next = B_DILATE;
            B_DILATE:
                priority if (s2_ok)
                    state_next = cmd_reg.last ? B_DIV : B_PUT;
                else if (cmd_reg.kind == CMD_EMIT)
                    state_next = B_READ;
                else
                    state_next = B_IDLE;
            B_DIV:
                if (div_cnt_reg == DIV_CNT_W'(SUM_W - 1))
                    state_next = B_PUT;
            B_PUT:
                if (out_free)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        pop      = 1'b0;
        rd_en    = 1'b0;
        go1      = 1'b0;
        go2      = 1'b0;
        clear    = 1'b0;
        div_init = 1'b0;
        div_step = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            B_IDLE:   pop = !q_status.empty;
            B_READ:   rd_en = 1'b1;
            B_ERODE:  go1 = 1'b1;
            B_DILATE:
            begin
                go2      = s1_ok_reg;
                div_init = s2_ok && cmd_reg.last;
            end
            B_DIV:    div_step = 1'b1;
            B_PUT:
            begin
                load_out = out_free;
                clear    = out_free && cmd_reg.last;
            end
            default:  ;
        endcase
    end

    always_comb
    begin
        rem_sh = {rem_reg, dq_reg[SUM_W-1]};
        ge     = (rem_sh >= {1'b0, frame.n});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= pop_cmd;
        if (go1)
        begin
            s1_bit_reg <= s1_bit;
            s1_ok_reg  <= s1_ok;
        end
        if (s2_ok)
            res_bit_reg <= s2_bit;
        if (div_init)
        begin
            rem_reg     <= '0;
            dq_reg      <= sum_reg;
            div_cnt_reg <= '0;
        end
        else if (div_step)
        begin
            rem_reg     <= ge ? N_W'(rem_sh - {1'b0, frame.n}) : N_W'(rem_sh);
            dq_reg      <= {dq_reg[SUM_W-2:0], ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (load_out)
        begin
            out_mask_reg <= res_bit_reg;
            out_last_reg <= cmd_reg.last;
            out_conf_reg <= cmd_reg.last ? dq_reg[PROB_W-1:0] : '0;
        end
    end

    // Frame sum and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
                sum_reg <= '0;
            else if (pop && (pop_cmd.kind == CMD_PIXEL))
                sum_reg <= sum_reg + SUM_W'(pop_cmd.prob);
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == B_IDLE) && !q_status.empty)
        else $error("command taken outside idle or from an empty queue");

    a_conf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_pixel) |-> (confidence == '0))
        else $error("confidence nonzero on a bit that is not the last");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (div_cnt_reg < DIV_CNT_W'(SUM_W)))
        else $error("divider ran past its step count");

    a_put_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PUT) |-> ($past(state_reg) == B_PUT) || ($past(state_reg) == B_DIV)
            || ($past(state_reg) == B_DILATE))
        else $error("output state entered without a result");
`endif

endmodule

`default_nettype wire

[rtl/threshold_open_mask_confidence.sv]
// Thresholds a raster frame of Q0.16 probabilities, opens the binary mask with a
// square window (erosion then dilation, radius of half the window size, off-image
// neighbours skipped) and returns at most one mask bit per request, the last bit
// of the frame carrying the truncated mean probability. The front end queues up to
// four commands; the back end pops a command while idle, then runs each raster
// step through column memory read, erosion and dilation, and loads the output
// register when a bit comes out and the output is free. A pixel request costs one
// step. The first drain request after the frame may run up to 2*(r*width + r) steps
// to bring the delayed window up to the next pending bit; later ones cost one step.
// The last bit adds a bit-serial division of the frame sum by the pixel
// count. Settings are latched on the first pixel of a frame; a new frame waits
// until the previous one is fully processed. Configuration writes are always ready.
// Depends on tomc_pkg, tomc_front, tomc_queue, tomc_back.
`default_nettype none

module threshold_open_mask_confidence
    import tomc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  req_type,
    input  wire logic [PROB_W-1:0]     probability,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       mask_bit,
    output logic                       last_pixel,
    output logic [PROB_W-1:0]          confidence
);

    // Front to queue.
    logic          push;
    cmd_t          push_cmd;
    // Queue to back.
    logic          pop;
    cmd_t          pop_cmd;
    queue_status_t q_status;
    // Back to front: hold a new frame until the back end drains; frame runs front to back.
    logic          back_idle;
    frame_t        frame;

    tomc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .probability (probability),
        .back_idle   (back_idle),
        .q_status    (q_status),
        .push        (push),
        .push_cmd    (push_cmd),
        .frame       (frame)
    );

    tomc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    tomc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .q_status   (q_status),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .back_idle  (back_idle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .mask_bit   (mask_bit),
        .last_pixel (last_pixel),
        .confidence (confidence)
    );

endmodule

`default_nettype wire
